### rtl/pclru_pkg.sv
// ----------------------------------------------------------------------------
// pclru_pkg
// Shared widths, register codes and control types of the page cache lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pclru_pkg;

	// Fixed field widths
	localparam int ADDR_W    = 25;
	localparam int RPC_W     = 12;
	localparam int SIU_W     = 7;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int STAMP_W   = 32;
	localparam int TOTAL_W   = 32;

	// Slots 0 and 1 are pinned; slot 1 is the padding slot
	localparam int PINNED_COUNT = 2;
	localparam int PAD_SLOT     = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REAL_PAGE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE    = CFG_IDX_W'(1);

	// Configuration reset values
	localparam logic [RPC_W-1:0] RPC_RESET = RPC_W'(2048);
	localparam logic [SIU_W-1:0] SIU_RESET = SIU_W'(64);

	// Enables of the page map and slot owner memories
	typedef struct packed {
		logic map_re;
		logic map_we;
		logic own_re;
		logic own_we;
	} dir_ctrl_t;

endpackage

`default_nettype wire

### rtl/pclru_dir.sv
// ----------------------------------------------------------------------------
// pclru_dir
// Page directory: page-to-slot map and slot-to-page owner memories, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pclru_dir #(
	parameter int MAX_ROM_PAGES = 2048,
	parameter int MAX_SLOTS     = 64,
	localparam int PAGE_W = $clog2(MAX_ROM_PAGES),
	localparam int SLOT_W = $clog2(MAX_SLOTS)
) (
	input  wire                        clk,
	input  pclru_pkg::dir_ctrl_t       ctrl,
	input  wire        [PAGE_W-1:0]    map_raddr,
	input  wire        [PAGE_W-1:0]    map_waddr,
	input  wire        [SLOT_W:0]      map_wdata,
	output logic       [SLOT_W:0]      map_rdata,
	input  wire        [SLOT_W-1:0]    own_raddr,
	input  wire        [SLOT_W-1:0]    own_waddr,
	input  wire        [PAGE_W:0]      own_wdata,
	output logic       [PAGE_W:0]      own_rdata
);

	// Entry layout: {valid, slot} and {valid, page}
	logic [SLOT_W:0] map_mem [MAX_ROM_PAGES];
	logic [PAGE_W:0] own_mem [MAX_SLOTS];

	// Page map: write, then registered read
	always_ff @(posedge clk) begin
		if (ctrl.map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (ctrl.map_re) begin
			map_rdata <= map_mem[map_raddr];
		end
	end

	// Slot owner: write, then registered read
	always_ff @(posedge clk) begin
		if (ctrl.own_we) begin
			own_mem[own_waddr] <= own_wdata;
		end
		if (ctrl.own_re) begin
			own_rdata <= own_mem[own_raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/pclru_scan.sv
// ----------------------------------------------------------------------------
// pclru_scan
// Slot stamp memory and victim search: reads one stamp a cycle from slot 2 up
// to the last live slot and keeps the oldest, lowest index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module pclru_scan #(
	parameter int MAX_SLOTS = 64,
	localparam int SLOT_W = $clog2(MAX_SLOTS)
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [SLOT_W-1:0]                last_slot,
	input  wire                              st_we,
	input  wire  [SLOT_W-1:0]                st_waddr,
	input  wire  [pclru_pkg::STAMP_W-1:0]    st_wdata,
	output logic                             done,
	output logic [SLOT_W-1:0]                victim
);

	logic [pclru_pkg::STAMP_W-1:0] stamp_mem [MAX_SLOTS];
	logic [pclru_pkg::STAMP_W-1:0] stamp_rd_s1;
	logic [pclru_pkg::STAMP_W-1:0] best_stamp_q;
	logic [SLOT_W-1:0]             issue_q;
	logic [SLOT_W-1:0]             idx_s1;
	logic [SLOT_W-1:0]             best_q;
	logic                          busy_q;
	logic                          vld_s1;
	logic                          last_s1;
	logic                          done_q;

	// Stamp memory: write port from the controller, read port for the scan
	always_ff @(posedge clk) begin
		if (st_we) begin
			stamp_mem[st_waddr] <= st_wdata;
		end
		if (busy_q) begin
			stamp_rd_s1 <= stamp_mem[issue_q];
		end
	end

	// Advance the read pointer and track which read is the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (issue_q == last_slot);
			done_q  <= vld_s1 && last_s1;
			if (start) begin
				busy_q  <= 1'b1;
				issue_q <= SLOT_W'(pclru_pkg::PINNED_COUNT);
			end else if (busy_q) begin
				issue_q <= issue_q + SLOT_W'(1);
				if (issue_q == last_slot) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Keep the smallest stamp; a strict compare leaves ties on the lower slot
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q;
		if (start) begin
			best_q       <= SLOT_W'(pclru_pkg::PINNED_COUNT);
			best_stamp_q <= '1;
		end else if (vld_s1 && (stamp_rd_s1 < best_stamp_q)) begin
			best_q       <= idx_s1;
			best_stamp_q <= stamp_rd_s1;
		end
	end

	assign done   = done_q;
	assign victim = best_q;

endmodule

`default_nettype wire

### rtl/page_cache_lru_lookup.sv
// Sequence: an out-of-range request goes straight to ST_OUT, a hit via ST_LOOK,
// a miss via ST_LOOK, ST_SCAN, ST_OWNER and ST_MAP; ST_OUT loads rsp_valid
// once the output is free. slots_in_use is held within 3 .. MAX_SLOTS and the
// miss scan reads one stamp a cycle from the stamp memory. One request runs at
// a time; the next is taken while the result moves out. Reset: a clearing pass
// over max(MAX_ROM_PAGES, MAX_SLOTS) holds req_stall high; cfg writes are taken.
// ----------------------------------------------------------------------------
// page_cache_lru_lookup
// Fully associative page cache lookup with least-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module page_cache_lru_lookup #(
	parameter int PAGE_BITS     = 14,
	parameter int MAX_ROM_PAGES = 2048,
	parameter int MAX_SLOTS     = 64,
	localparam int PAGE_W = $clog2(MAX_ROM_PAGES),
	localparam int SLOT_W = $clog2(MAX_SLOTS)
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [pclru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [pclru_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                  req_valid,
	output logic                                 req_stall,
	input  wire  [pclru_pkg::ADDR_W-1:0]         byte_offset,
	output logic                                 rsp_valid,
	input  wire                                  rsp_stall,
	output logic [SLOT_W-1:0]                    slot_index,
	output logic [PAGE_BITS-1:0]                 offset_in_page,
	output logic                                 out_of_range,
	output logic                                 was_hit,
	output logic                                 fill_needed,
	output logic [PAGE_W-1:0]                    fill_page,
	output logic [pclru_pkg::TOTAL_W-1:0]        hit_total,
	output logic [pclru_pkg::TOTAL_W-1:0]        miss_total
);

	localparam int CLR_DEPTH = (MAX_ROM_PAGES > MAX_SLOTS) ? MAX_ROM_PAGES : MAX_SLOTS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_OWNER,
		ST_MAP,
		ST_OUT
	} state_t;

	state_t                            state_q;
	logic [CLR_W-1:0]                  clr_q;
	logic [pclru_pkg::RPC_W-1:0]       rpc_q;
	logic [pclru_pkg::SIU_W-1:0]       siu_q;
	logic [pclru_pkg::STAMP_W-1:0]     use_q;
	logic [pclru_pkg::TOTAL_W-1:0]     hits_q;
	logic [pclru_pkg::TOTAL_W-1:0]     misses_q;
	logic [PAGE_W-1:0]                 page_q;
	logic [PAGE_BITS-1:0]              offs_q;
	logic [SLOT_W-1:0]                 r_slot_q;
	logic                              r_oor_q;
	logic                              r_hit_q;
	logic                              r_fill_q;

	logic [31:0]                       page_full;
	logic [31:0]                       limit;
	logic [31:0]                       live_n;
	logic [SLOT_W-1:0]                 last_slot;
	logic                              req_oor;
	logic                              out_free;
	logic                              accept;
	logic [pclru_pkg::STAMP_W-1:0]     use_next;

	pclru_pkg::dir_ctrl_t              dir_ctrl;
	logic [PAGE_W-1:0]                 map_waddr;
	logic [SLOT_W:0]                   map_wdata;
	logic [SLOT_W:0]                   map_rdata;
	logic                              map_hit;
	logic [SLOT_W-1:0]                 map_slot;
	logic [SLOT_W-1:0]                 own_waddr;
	logic [PAGE_W:0]                   own_wdata;
	logic [PAGE_W:0]                   own_rdata;
	logic                              own_valid;
	logic [PAGE_W-1:0]                 own_page;
	logic                              st_we;
	logic [SLOT_W-1:0]                 st_waddr;
	logic [pclru_pkg::STAMP_W-1:0]     st_wdata;
	logic                              scan_start;
	logic                              scan_done;
	logic [SLOT_W-1:0]                 victim;
	logic                              clr_first;

	// Split the offset and hold the page count within the map depth
	assign page_full = 32'(byte_offset >> PAGE_BITS);
	assign limit     = (32'(rpc_q) > 32'(MAX_ROM_PAGES)) ? 32'(MAX_ROM_PAGES) : 32'(rpc_q);
	assign req_oor   = (page_full >= limit);

	// Hold the live slot count within the pinned slots plus one and the maximum
	always_comb begin
		live_n = 32'(siu_q);
		if (live_n < 32'(pclru_pkg::PINNED_COUNT + 1)) begin
			live_n = 32'(pclru_pkg::PINNED_COUNT + 1);
		end
		if (live_n > 32'(MAX_SLOTS)) begin
			live_n = 32'(MAX_SLOTS);
		end
	end
	assign last_slot = SLOT_W'(live_n - 32'd1);

	// Request handshake: take a request when idle or while the result moves out
	assign out_free  = !rsp_valid || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) || ((state_q == ST_OUT) && out_free));
	assign accept    = req_valid && !req_stall;

	assign use_next  = use_q + pclru_pkg::STAMP_W'(1);
	assign map_hit   = map_rdata[SLOT_W];
	assign map_slot  = map_rdata[SLOT_W-1:0];
	assign own_valid = own_rdata[PAGE_W];
	assign own_page  = own_rdata[PAGE_W-1:0];
	assign clr_first = (clr_q == '0);

	assign scan_start = (state_q == ST_LOOK) && !map_hit;

	// Drive the memory ports from the current state
	always_comb begin
		dir_ctrl        = '0;
		dir_ctrl.map_re = accept && !req_oor;
		dir_ctrl.own_re = (state_q == ST_SCAN) && scan_done;
		map_waddr       = page_q;
		map_wdata       = '0;
		own_waddr       = r_slot_q;
		own_wdata       = {1'b1, page_q};
		st_we           = 1'b0;
		st_waddr        = victim;
		st_wdata        = use_next;
		case (state_q)
			ST_CLEAR: begin
				dir_ctrl.map_we = (32'(clr_q) < 32'(MAX_ROM_PAGES));
				map_waddr       = PAGE_W'(clr_q);
				map_wdata       = {clr_first, SLOT_W'(0)};
				dir_ctrl.own_we = (32'(clr_q) < 32'(MAX_SLOTS));
				own_waddr       = SLOT_W'(clr_q);
				own_wdata       = {clr_first, PAGE_W'(0)};
				st_we           = (32'(clr_q) < 32'(MAX_SLOTS));
				st_waddr        = SLOT_W'(clr_q);
				st_wdata        = (32'(clr_q) < 32'(pclru_pkg::PINNED_COUNT)) ? '1 : '0;
			end
			ST_LOOK: begin
				st_we    = map_hit;
				st_waddr = map_slot;
			end
			ST_SCAN: begin
				st_we = scan_done;
			end
			ST_OWNER: begin
				dir_ctrl.map_we = own_valid;
				map_waddr       = own_page;
				dir_ctrl.own_we = 1'b1;
			end
			ST_MAP: begin
				dir_ctrl.map_we = 1'b1;
				map_wdata       = {1'b1, r_slot_q};
			end
			default: begin
			end
		endcase
	end

	pclru_dir #(
		.MAX_ROM_PAGES (MAX_ROM_PAGES),
		.MAX_SLOTS     (MAX_SLOTS)
	) u_dir (
		.clk       (clk),
		.ctrl      (dir_ctrl),
		.map_raddr (PAGE_W'(page_full)),
		.map_waddr (map_waddr),
		.map_wdata (map_wdata),
		.map_rdata (map_rdata),
		.own_raddr (victim),
		.own_waddr (own_waddr),
		.own_wdata (own_wdata),
		.own_rdata (own_rdata)
	);

	pclru_scan #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.last_slot (last_slot),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.done      (scan_done),
		.victim    (victim)
	);

	// Sequencer, configuration, counters and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			rpc_q          <= pclru_pkg::RPC_RESET;
			siu_q          <= pclru_pkg::SIU_RESET;
			use_q          <= '0;
			hits_q         <= '0;
			misses_q       <= '0;
			page_q         <= '0;
			offs_q         <= '0;
			r_slot_q       <= '0;
			r_oor_q        <= 1'b0;
			r_hit_q        <= 1'b0;
			r_fill_q       <= 1'b0;
			rsp_valid      <= 1'b0;
			slot_index     <= '0;
			offset_in_page <= '0;
			out_of_range   <= 1'b0;
			was_hit        <= 1'b0;
			fill_needed    <= 1'b0;
			fill_page      <= '0;
			hit_total      <= '0;
			miss_total     <= '0;
		end else begin
			// Register writes
			if (cfg_we) begin
				case (cfg_index)
					pclru_pkg::CFG_REAL_PAGE_COUNT: rpc_q <= cfg_data[pclru_pkg::RPC_W-1:0];
					pclru_pkg::CFG_SLOTS_IN_USE:    siu_q <= cfg_data[pclru_pkg::SIU_W-1:0];
					default: begin
					end
				endcase
			end

			// Load the response register, drop it once taken
			if ((state_q == ST_OUT) && out_free) begin
				rsp_valid      <= 1'b1;
				slot_index     <= r_slot_q;
				offset_in_page <= offs_q;
				out_of_range   <= r_oor_q;
				was_hit        <= r_hit_q;
				fill_needed    <= r_fill_q;
				fill_page      <= r_fill_q ? page_q : '0;
				hit_total      <= hits_q;
				miss_total     <= misses_q;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOOK: begin
					if (map_hit) begin
						use_q    <= use_next;
						hits_q   <= hits_q + pclru_pkg::TOTAL_W'(1);
						r_slot_q <= map_slot;
						r_hit_q  <= 1'b1;
						r_fill_q <= 1'b0;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						r_slot_q <= victim;
						use_q    <= use_next;
						state_q  <= ST_OWNER;
					end
				end
				ST_OWNER: begin
					state_q <= ST_MAP;
				end
				ST_MAP: begin
					misses_q <= misses_q + pclru_pkg::TOTAL_W'(1);
					r_hit_q  <= 1'b0;
					r_fill_q <= 1'b1;
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					// Go idle unless a new request is taken right away
					if (out_free && !accept) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
				end
			endcase

			// Capture an accepted request; out-of-range pages finish at once
			if (accept) begin
				page_q <= PAGE_W'(page_full);
				offs_q <= byte_offset[PAGE_BITS-1:0];
				if (req_oor) begin
					r_slot_q <= SLOT_W'(pclru_pkg::PAD_SLOT);
					r_oor_q  <= 1'b1;
					r_hit_q  <= 1'b0;
					r_fill_q <= 1'b0;
					state_q  <= ST_OUT;
				end else begin
					r_oor_q <= 1'b0;
					state_q <= ST_LOOK;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/pclru_checker.sv
// ----------------------------------------------------------------------------
// pclru_checker
// Port-level checks of the page cache lookup responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pclru_checker #(
	parameter int PAGE_BITS     = 14,
	parameter int MAX_ROM_PAGES = 2048,
	parameter int MAX_SLOTS     = 64,
	localparam int PAGE_W = $clog2(MAX_ROM_PAGES),
	localparam int SLOT_W = $clog2(MAX_SLOTS)
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              rsp_valid,
	input wire                              rsp_stall,
	input wire [SLOT_W-1:0]                 slot_index,
	input wire                              out_of_range,
	input wire                              was_hit,
	input wire                              fill_needed,
	input wire [PAGE_W-1:0]                 fill_page,
	input wire [pclru_pkg::TOTAL_W-1:0]     hit_total,
	input wire [pclru_pkg::TOTAL_W-1:0]     miss_total
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(slot_index)
			&& $stable(hit_total) && $stable(miss_total))
		else $error("stalled response changed");

	// Every response is exactly one of out-of-range, hit or miss
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot({out_of_range, was_hit, fill_needed}))
		else $error("response kind not one-hot");

	// Out-of-range pages read the padding slot and ask for no fill
	a_pad_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_of_range |-> (slot_index == SLOT_W'(pclru_pkg::PAD_SLOT))
			&& (fill_page == '0))
		else $error("out-of-range response not on padding slot");

	// A fill never lands on a pinned slot
	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && fill_needed |-> (32'(slot_index) >= 32'(pclru_pkg::PINNED_COUNT)))
		else $error("fill on pinned slot");

endmodule

bind page_cache_lru_lookup pclru_checker #(
	.PAGE_BITS     (PAGE_BITS),
	.MAX_ROM_PAGES (MAX_ROM_PAGES),
	.MAX_SLOTS     (MAX_SLOTS)
) u_pclru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.slot_index   (slot_index),
	.out_of_range (out_of_range),
	.was_hit      (was_hit),
	.fill_needed  (fill_needed),
	.fill_page    (fill_page),
	.hit_total    (hit_total),
	.miss_total   (miss_total)
);

`default_nettype wire
